@@ hw/rtl/perlin_noise_2d_macros.svh @@
// Assertion macros used by the noise generator top level.
`ifndef PERLIN_NOISE_2D_MACROS_SVH
`define PERLIN_NOISE_2D_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PN2D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pn2d check failed");

// Implication with a fixed number of cycles between cause and effect.
`define PN2D_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("pn2d latency check failed");

`endif

@@ hw/rtl/pn2d_pkg.sv @@
// Shared types and constants of the 2D gradient noise generator.
`default_nettype none

package pn2d_pkg;

  // Default configuration of the table and the fixed-point format.
  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // Permutation entries are one byte wide.
  localparam int VAL_W = 8;

  // Operation codes of an input transfer.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Gradient selection codes (hash modulo four).
  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_NP = 2'd1;
  localparam logic [1:0] GRAD_NN = 2'd2;
  localparam logic [1:0] GRAD_PN = 2'd3;

  // Input transfer payload.
  typedef struct packed {
    logic               operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         entry_index;
    logic [7:0]         entry_value;
  } in_t;

  // Result transfer payload.
  typedef struct packed {
    logic signed [17:0] noise_value;
    logic               is_sample;
  } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/perlin_noise_2d.sv @@
// Top level of the 2D gradient noise generator with a loadable permutation table.
//
// Channel   Direction  Handshake                   Payload
// input     in         start high, busy low        in_data  (pn2d_pkg::in_t)
// result    out        out_valid strobe, 1 cycle   out_data (pn2d_pkg::out_t)
//
// One item is taken every cycle while busy is low.
// The pipeline holds two dependent table lookups, the fade polynomial
// and the two blend stages, each separated by registers.
// After reset the table is filled with its identity contents, one entry per
// cycle, while busy stays high.
// A load writes all three table copies at its transfer edge; earlier samples
// still in flight read the old contents. Results cannot be stalled.
`default_nettype none

module perlin_noise_2d
  import pn2d_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

`include "perlin_noise_2d_macros.svh"

  localparam int F   = FRAC_BITS;
  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int DW  = F + 2;   // corner dot products
  localparam int LW  = F + 3;   // blended values
  localparam int LAT = 7;
  localparam int SH_R = (F > 16) ? (F - 16) : 0;
  localparam int SH_L = (F < 16) ? (16 - F) : 0;
  localparam logic signed [39:0] RND_OUT = (40'sd1 <<< SH_R) >>> 1;
  localparam logic [2*F+5:0] HALF = (2*F+6)'(1) << (F - 1);
  localparam logic signed [DW-1:0] ONE_D = DW'(1) << F;
  localparam logic [F:0] ONE_U = (F+1)'(1) << F;

  // Dot product of a corner offset with one of four diagonal gradients.
  function automatic logic signed [DW-1:0] grad_dot(input logic [1:0] h,
      input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
    logic signed [DW-1:0] r;
    case (h)
      GRAD_PP: r = dx + dy;
      GRAD_NP: r = dy - dx;
      GRAD_NN: r = -dx - dy;
      GRAD_PN: r = dx - dy;
      default: r = dx + dy;
    endcase
    return r;
  endfunction

  // Fade front half: t^2 and 6t^2, rounded.
  function automatic logic [2*F+3:0] fade_sq(input logic [F-1:0] t);
    logic [2*F+3:0] tt;
    logic [2*F+3:0] s2;
    logic [2*F+3:0] s6;
    tt = (2*F+4)'(t) * (2*F+4)'(t);
    s2 = (tt + (2*F+4)'(HALF)) >> F;
    s6 = ((tt * (2*F+4)'(6)) + (2*F+4)'(HALF)) >> F;
    return {s6[F+2:0], s2[F:0]};
  endfunction

  // One rounded linear blend step.
  function automatic logic signed [LW-1:0] lerp(input logic [F:0] w,
      input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
    logic signed [LW:0]    d;
    logic signed [F+1:0]   ws;
    logic signed [2*F+5:0] p;
    d  = (LW+1)'(b) - (LW+1)'(a);
    ws = $signed({1'b0, w});
    p  = (2*F+6)'(d) * (2*F+6)'(ws);
    p  = (p + $signed(HALF)) >>> F;
    return a + LW'(p);
  endfunction

  // Handshake and table clearing after reset.
  logic          clr_r;
  logic [IW-1:0] clr_idx_r;
  logic          in_acc;
  logic          load_acc;

  assign busy     = clr_r;
  assign in_acc   = start && !busy;
  assign load_acc = in_acc && (in_data.operation == OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + IW'(1);
      if (clr_idx_r == {IW{1'b1}}) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Shared write port of the three table copies.
  logic [IW-1:0]    we_addr;
  logic [VAL_W-1:0] we_data;
  logic [IW+7:0]    ld_idx_ext;
  logic [IW+7:0]    clr_idx_ext;
  logic             we;

  assign ld_idx_ext  = (IW+8)'(in_data.entry_index);
  assign clr_idx_ext = (IW+8)'(clr_idx_r);
  assign we      = clr_r || load_acc;
  assign we_addr = clr_r ? clr_idx_r : ld_idx_ext[IW-1:0];
  assign we_data = clr_r ? clr_idx_ext[VAL_W-1:0] : in_data.entry_value;

  // Cell coordinates and fractions of the incoming point.
  logic signed [63:0] px64;
  logic signed [63:0] py64;
  logic [IW-1:0]      cx;
  logic [IW-1:0]      cx1;

  assign px64 = 64'(in_data.point_x);
  assign py64 = 64'(in_data.point_y);
  assign cx   = px64[F+IW-1:F];
  assign cx1  = cx + IW'(1);

  // Stage 1 registers: first lookup in flight.
  logic          v1_r;
  logic          op1_r;
  logic [IW-1:0] cy1_r;
  logic [F-1:0]  xf1_r;
  logic [F-1:0]  yf1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    op1_r <= in_data.operation;
    cy1_r <= py64[F+IW-1:F];
    xf1_r <= px64[F-1:0];
    yf1_r <= py64[F-1:0];
  end

  logic [VAL_W-1:0] perm_a;
  logic [VAL_W-1:0] perm_b;

  pn2d_perm_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_ram_a (
    .clk    (clk),
    .we     (we),
    .waddr  (we_addr),
    .wdata  (we_data),
    .raddr0 (cx),
    .raddr1 (cx1),
    .rdata0 (perm_a),
    .rdata1 (perm_b)
  );

  // Second lookup addresses, wrapped to the table size.
  logic [IW+7:0] sum_a;
  logic [IW+7:0] sum_b;
  logic [IW-1:0] addr_bl;
  logic [IW-1:0] addr_tl;
  logic [IW-1:0] addr_br;
  logic [IW-1:0] addr_tr;

  assign sum_a   = (IW+8)'(perm_a) + (IW+8)'(cy1_r);
  assign sum_b   = (IW+8)'(perm_b) + (IW+8)'(cy1_r);
  assign addr_bl = sum_a[IW-1:0];
  assign addr_tl = sum_a[IW-1:0] + IW'(1);
  assign addr_br = sum_b[IW-1:0];
  assign addr_tr = sum_b[IW-1:0] + IW'(1);

  logic [VAL_W-1:0] h_bl;
  logic [VAL_W-1:0] h_tl;
  logic [VAL_W-1:0] h_br;
  logic [VAL_W-1:0] h_tr;

  pn2d_perm_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_ram_b (
    .clk    (clk),
    .we     (we),
    .waddr  (we_addr),
    .wdata  (we_data),
    .raddr0 (addr_bl),
    .raddr1 (addr_tl),
    .rdata0 (h_bl),
    .rdata1 (h_tl)
  );

  pn2d_perm_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_ram_c (
    .clk    (clk),
    .we     (we),
    .waddr  (we_addr),
    .wdata  (we_data),
    .raddr0 (addr_br),
    .raddr1 (addr_tr),
    .rdata0 (h_br),
    .rdata1 (h_tr)
  );

  // Stage 2: squares of the fractions for the fade curve.
  logic [2*F+3:0] fsq_x;
  logic [2*F+3:0] fsq_y;
  logic           v2_r;
  logic           op2_r;
  logic [F-1:0]   xf2_r;
  logic [F-1:0]   yf2_r;
  logic [F:0]     t2x_r;
  logic [F:0]     t2y_r;
  logic [F+2:0]   q6x_r;
  logic [F+2:0]   q6y_r;

  assign fsq_x = fade_sq(xf1_r);
  assign fsq_y = fade_sq(yf1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r <= op1_r;
    xf2_r <= xf1_r;
    yf2_r <= yf1_r;
    t2x_r <= fsq_x[F:0];
    t2y_r <= fsq_y[F:0];
    q6x_r <= fsq_x[2*F+3:F+1];
    q6y_r <= fsq_y[2*F+3:F+1];
  end

  // Stage 3: corner dot products, t^3 and the fade polynomial.
  logic signed [DW-1:0] dx0;
  logic signed [DW-1:0] dy0;
  logic signed [DW-1:0] dx1;
  logic signed [DW-1:0] dy1;
  logic [2*F+2:0]       t3x_w;
  logic [2*F+2:0]       t3y_w;
  logic signed [F+5:0]  px_w;
  logic signed [F+5:0]  py_w;

  assign dx0   = $signed(DW'(xf2_r));
  assign dy0   = $signed(DW'(yf2_r));
  assign dx1   = dx0 - ONE_D;
  assign dy1   = dy0 - ONE_D;
  assign t3x_w = ((2*F+3)'(t2x_r) * (2*F+3)'(xf2_r) + (2*F+3)'(HALF)) >> F;
  assign t3y_w = ((2*F+3)'(t2y_r) * (2*F+3)'(yf2_r) + (2*F+3)'(HALF)) >> F;
  assign px_w  = $signed((F+6)'(10) << F) - $signed((F+6)'(15) * (F+6)'(xf2_r))
               + $signed((F+6)'(q6x_r));
  assign py_w  = $signed((F+6)'(10) << F) - $signed((F+6)'(15) * (F+6)'(yf2_r))
               + $signed((F+6)'(q6y_r));

  logic                 v3_r;
  logic                 op3_r;
  logic signed [DW-1:0] bl3_r;
  logic signed [DW-1:0] tl3_r;
  logic signed [DW-1:0] br3_r;
  logic signed [DW-1:0] tr3_r;
  logic [F:0]           t3x_r;
  logic [F:0]           t3y_r;
  logic [F+3:0]         px_r;
  logic [F+3:0]         py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    op3_r <= op2_r;
    bl3_r <= grad_dot(h_bl[1:0], dx0, dy0);
    br3_r <= grad_dot(h_br[1:0], dx1, dy0);
    tl3_r <= grad_dot(h_tl[1:0], dx0, dy1);
    tr3_r <= grad_dot(h_tr[1:0], dx1, dy1);
    t3x_r <= t3x_w[F:0];
    t3y_r <= t3y_w[F:0];
    px_r  <= px_w[F+3:0];
    py_r  <= py_w[F+3:0];
  end

  // Stage 4: final fade products, clamped to one.
  logic [2*F+5:0] fx_w;
  logic [2*F+5:0] fy_w;
  logic           v4_r;
  logic           op4_r;
  logic signed [DW-1:0] bl4_r;
  logic signed [DW-1:0] tl4_r;
  logic signed [DW-1:0] br4_r;
  logic signed [DW-1:0] tr4_r;
  logic [F:0]     u4_r;
  logic [F:0]     v4w_r;

  assign fx_w = ((2*F+6)'(px_r) * (2*F+6)'(t3x_r) + HALF) >> F;
  assign fy_w = ((2*F+6)'(py_r) * (2*F+6)'(t3y_r) + HALF) >> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    op4_r <= op3_r;
    bl4_r <= bl3_r;
    tl4_r <= tl3_r;
    br4_r <= br3_r;
    tr4_r <= tr3_r;
    u4_r  <= (fx_w > (2*F+6)'(ONE_U)) ? ONE_U : fx_w[F:0];
    v4w_r <= (fy_w > (2*F+6)'(ONE_U)) ? ONE_U : fy_w[F:0];
  end

  // Stage 5: blend along y on the left and right edges.
  logic                 v5_r;
  logic                 op5_r;
  logic signed [LW-1:0] left5_r;
  logic signed [LW-1:0] right5_r;
  logic [F:0]           u5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    op5_r    <= op4_r;
    u5_r     <= u4_r;
    left5_r  <= lerp(v4w_r, LW'(bl4_r), LW'(tl4_r));
    right5_r <= lerp(v4w_r, LW'(br4_r), LW'(tr4_r));
  end

  // Stage 6: blend along x.
  logic                 v6_r;
  logic                 op6_r;
  logic signed [LW-1:0] n6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    op6_r <= op5_r;
    n6_r  <= lerp(u5_r, left5_r, right5_r);
  end

  // Output stage: rescale to 16 fraction bits and saturate.
  logic signed [39:0] nw;
  logic signed [39:0] ns;
  logic signed [17:0] sat;
  out_t               out_nxt;
  out_t               out_r;
  logic               out_valid_r;

  always_comb begin
    nw = 40'(n6_r);
    ns = ((nw + RND_OUT) >>> SH_R) <<< SH_L;
    if (ns > 40'sd131071) begin
      sat = 18'sd131071;
    end else if (ns < -40'sd131072) begin
      sat = -18'sd131072;
    end else begin
      sat = ns[17:0];
    end
    if (op6_r == OP_LOAD) begin
      out_nxt.noise_value = '0;
      out_nxt.is_sample   = 1'b0;
    end else begin
      out_nxt.noise_value = sat;
      out_nxt.is_sample   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every accepted transfer yields a valid result.
  `PN2D_ASSERT_DELAY(a_fixed_latency, in_acc, LAT, out_valid)
  // No result can leave while the table is still being cleared.
  `PN2D_ASSERT_NOW(a_no_result_in_clear, out_valid, !clr_r)
  // Load results carry a zero noise value.
  `PN2D_ASSERT_NOW(a_load_zero, out_valid && !out_data.is_sample, out_data.noise_value == '0)

endmodule

`default_nettype wire

@@ hw/rtl/pn2d_perm_ram.sv @@
// Permutation table copy: one write port, two registered read ports.
`default_nettype none

module pn2d_perm_ram
  import pn2d_pkg::*;
#(
  parameter int DEPTH = TABLE_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr0,
  input  wire logic [AW-1:0]    raddr1,
  output logic      [VAL_W-1:0] rdata0,
  output logic      [VAL_W-1:0] rdata1
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata0_r;
  logic [VAL_W-1:0] rdata1_r;

  // Write port; reads return the contents from before a same-cycle write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

@@ tb/perlin_noise_2d_test.sv @@
// Self-checking testbench of the 2D gradient noise generator with its permutation table.
`timescale 1ns / 100ps

module perlin_noise_2d_test;
  import pn2d_pkg::*;

  localparam int TBL = TABLE_SIZE_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  // Scoreboard: keeps its own copy of the table and the queue of expected noise results.
  class noise_scoreboard;
    logic [7:0] perm [TBL];
    out_t noise_q[$];
    int failures;

    function new();
      for (int i = 0; i < TBL; i++) perm[i] = i[7:0];
      failures = 0;
    endfunction

    // Round v / 2^sh to nearest, ties up.
    function longint rnd_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint fade(longint t);
      longint t2, t3, p, f;
      t2 = rnd_shift(t * t, FB);
      t3 = rnd_shift(t2 * t, FB);
      p = 10 * ONE - 15 * t + rnd_shift(6 * t * t, FB);
      f = rnd_shift(p * t3, FB);
      return (f > ONE) ? ONE : f;
    endfunction

    function longint blend(longint w, longint a, longint b);
      return a + rnd_shift(w * (b - a), FB);
    endfunction

    function logic [1:0] corner(int cx, int cy);
      logic [7:0] first;
      first = perm[cx % TBL];
      return perm[(int'(first) + cy) % TBL][1:0];
    endfunction

    function longint grad(logic [1:0] g, longint dx, longint dy);
      case (g)
        GRAD_PP: return dx + dy;
        GRAD_NP: return -dx + dy;
        GRAD_NN: return -dx - dy;
        default: return dx - dy;
      endcase
    endfunction

    function logic signed [17:0] noise_at(logic [31:0] px, logic [31:0] py);
      int cx, cy;
      longint xf, yf, bl, br, tl, tr, u, v, n;
      cx = int'(px[31:FB]) % TBL;
      cy = int'(py[31:FB]) % TBL;
      xf = longint'(px[FB-1:0]);
      yf = longint'(py[FB-1:0]);
      bl = grad(corner(cx, cy), xf, yf);
      br = grad(corner(cx + 1, cy), xf - ONE, yf);
      tl = grad(corner(cx, cy + 1), xf, yf - ONE);
      tr = grad(corner(cx + 1, cy + 1), xf - ONE, yf - ONE);
      u = fade(xf);
      v = fade(yf);
      n = blend(u, blend(v, bl, tl), blend(v, br, tr));
      if (n > 131071) n = 131071;
      if (n < -131072) n = -131072;
      return n[17:0];
    endfunction

    // Notes one accepted input transfer.
    function void note_input(in_t it);
      out_t r;
      if (it.operation == OP_LOAD) begin
        perm[int'(it.entry_index) % TBL] = it.entry_value;
        r.noise_value = '0;
        r.is_sample = 1'b0;
      end else begin
        r.noise_value = noise_at(it.point_x, it.point_y);
        r.is_sample = 1'b1;
      end
      noise_q.push_back(r);
    endfunction

    // Checks one result transfer against the oldest expectation.
    function void check_result(out_t got);
      out_t want;
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result noise=%0d is_sample=%0b", $time,
                 got.noise_value, got.is_sample);
        failures++;
        return;
      end
      want = noise_q.pop_front();
      if (got.noise_value !== want.noise_value) begin
        $display("%0t: noise_value expected %0d actual %0d", $time,
                 want.noise_value, got.noise_value);
        failures++;
      end
      if (got.is_sample !== want.is_sample) begin
        $display("%0t: is_sample expected %0b actual %0b", $time,
                 want.is_sample, got.is_sample);
        failures++;
      end
    endfunction

    function int pending();
      return noise_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  int cycles = 0;
  noise_scoreboard sb = new();

  perlin_noise_2d u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor and run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Presents one item from a falling edge and holds it until the transfer.
  task send(in_t it);
    start = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task pause(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function in_t sample_item(logic [31:0] px, logic [31:0] py);
    in_t it;
    it = '0;
    it.operation = OP_SAMPLE;
    it.point_x = px;
    it.point_y = py;
    it.entry_index = 8'($urandom);
    it.entry_value = 8'($urandom);
    return it;
  endfunction

  function in_t load_item(logic [7:0] idx, logic [7:0] val);
    in_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  // Random point; sometimes placed on a cell edge or near one.
  function logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 5))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[31:24] = {8{c[31]}};
      default: ;
    endcase
    return c;
  endfunction

  int idle_pct;

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: coordinate extremes, cell edges and table corners.
    send(sample_item(32'h0000_0000, 32'h0000_0000));
    send(sample_item(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(sample_item(32'h8000_0000, 32'h8000_0000));
    send(sample_item(32'h7FFF_FFFF, 32'h8000_0000));
    send(sample_item(32'hFFFF_FFFF, 32'h0000_FFFF));
    send(sample_item(32'h00FF_8000, 32'h00FF_8000));
    send(sample_item(32'h0000_8000, 32'h0000_8000));
    send(sample_item(32'h0000_0001, 32'hFFFF_0000));
    send(load_item(8'd0, 8'd255));
    send(load_item(8'd255, 8'd0));
    send(sample_item(32'h00FF_4000, 32'h00FF_C000));
    send(sample_item(32'h0000_4000, 32'h00FF_2000));
    send(load_item(8'd1, 8'd3));
    send(load_item(8'd2, 8'd2));
    send(sample_item(32'h0001_1234, 32'h0000_ABCD));
    send(sample_item(32'hFFFF_8000, 32'hFFFF_8000));
    send(load_item(8'hAA, 8'h55));
    send(load_item(8'h55, 8'hAA));
    send(sample_item(32'h0055_7777, 32'h00AA_3333));

    // Hold off until every expected result has come.
    pause(1);
    while (sb.pending() != 0) @(negedge clk);
    pause(10);

    // Random part in four idling phases; each idle cycle is drawn on its own.
    for (int i = 0; i < 1340; i++) begin
      case (i / 335)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      if ($urandom_range(0, 9) == 0) send(load_item(8'($urandom), 8'($urandom)));
      else send(sample_item(rand_coord(), rand_coord()));
      while ($urandom_range(0, 99) < idle_pct) pause(1);
    end
    pause(1);

    // Drain and settle.
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
